@@ sv/scaler_ratio_and_coef_table_assert.svh @@
// Assertion macros for the top RTL file of the resize coefficient table.
`ifndef SCALER_RATIO_AND_COEF_TABLE_ASSERT_SVH
`define SCALER_RATIO_AND_COEF_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCRT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCRT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/scrt_pkg.sv @@
package scrt_pkg;

    localparam int MAX_TERM_DEF  = 20;
    localparam int SIZE_BITS_DEF = 12;
    localparam int WEIGHT_BITS   = 8;
    localparam logic [WEIGHT_BITS-1:0] FULL_WEIGHT = 8'd128;
    localparam logic [WEIGHT_BITS-1:0] HALF_WEIGHT = 8'd64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_ERR,
        ST_CMP,
        ST_SZ_MUL,
        ST_SZ_DIV,
        ST_SZ_WAIT,
        ST_SZ_STEP,
        ST_NMOD_DIV,
        ST_NMOD_WAIT,
        ST_W_DIV,
        ST_W_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_SIZE,
        DIV_NMOD,
        DIV_WEIGHT
    } div_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     srch_mul;
        logic     srch_err;
        logic     srch_cmp;
        logic     srch_adv;
        logic     sz_mul;
        logic     div_start;
        div_sel_t div_sel;
        logic     sz_load;
        logic     sz_step;
        logic     ent_init;
        logic     emit;
        logic     ent_adv;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic cand_last;
        logic div_busy;
        logic sz_stop;
        logic ent_last;
        logic out_fire;
    } stat_t;

endpackage

@@ sv/scaler_ratio_and_coef_table.sv @@
// Sequence: a multiply, a subtract and a compare per ratio candidate (skipped ones are passed
// over), a serial divide, one step per trimmed pixel of the size search (up to the source
// size), a second divide, then a serial divide per coefficient beat.
// Throughput: one item at a time; the next item is taken once the last beat has left.
// Reset: aresetn is synchronous and active low; it idles the controller and drops m_valid.
module scaler_ratio_and_coef_table #(
    parameter int MAX_TERM  = scrt_pkg::MAX_TERM_DEF,
    parameter int SIZE_BITS = scrt_pkg::SIZE_BITS_DEF,
    localparam int TB = $clog2(MAX_TERM + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [SIZE_BITS-1:0]             s_src_size,
    input  logic [SIZE_BITS-1:0]             s_dst_size,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [TB-1:0]                    m_entry_index,
    output logic [scrt_pkg::WEIGHT_BITS-1:0] m_weight,
    output logic                             m_take_input,
    output logic                             m_give_output,
    output logic [TB-1:0]                    m_ratio_num,
    output logic [TB-1:0]                    m_ratio_den,
    output logic                             m_is_upscale,
    output logic [SIZE_BITS-1:0]             m_achieved_size,
    output logic [SIZE_BITS-1:0]             m_trim,
    output logic                             m_last_entry
);

`include "scaler_ratio_and_coef_table_assert.svh"

    // The controller sequences the search, the size loop and the beats; the datapath
    // holds every counter and arithmetic unit and reports back through status flags.
    scrt_pkg::cmd_t  cmd;
    scrt_pkg::stat_t stat;

    scrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    scrt_dp #(
        .MAX_TERM  (MAX_TERM),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_src_size      (s_src_size),
        .s_dst_size      (s_dst_size),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_entry_index   (m_entry_index),
        .m_weight        (m_weight),
        .m_take_input    (m_take_input),
        .m_give_output   (m_give_output),
        .m_ratio_num     (m_ratio_num),
        .m_ratio_den     (m_ratio_den),
        .m_is_upscale    (m_is_upscale),
        .m_achieved_size (m_achieved_size),
        .m_trim          (m_trim),
        .m_last_entry    (m_last_entry)
    );

    // The block never takes a new item while a beat is on offer.
    `SCRT_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "input taken during output")
    // The final beat of a run returns the block to idle.
    `SCRT_ASSERT_NEXT(a_last_idle, aclk, aresetn, m_valid && m_ready && m_last_entry, s_ready, "no idle after last beat")
    // Entry index stays inside the table that the chosen ratio defines.
    `SCRT_ASSERT_NOW(a_idx_range, aclk, aresetn, m_valid, m_is_upscale ? (m_entry_index < m_ratio_den) : (m_entry_index < m_ratio_num), "entry index out of range")

endmodule

@@ sv/scrt_ctrl.sv @@
module scrt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  scrt_pkg::stat_t  stat,
    output scrt_pkg::cmd_t   cmd
);

    scrt_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scrt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = scrt_pkg::DIV_SIZE;
        s_ready    = 1'b0;
        unique case (state_reg)
            scrt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = scrt_pkg::ST_CHK;
                end
            end
            scrt_pkg::ST_CHK: begin
                if (stat.skip) begin
                    cmd.srch_adv = 1'b1;
                end else begin
                    cmd.srch_mul = 1'b1;
                    state_next   = scrt_pkg::ST_ERR;
                end
            end
            scrt_pkg::ST_ERR: begin
                cmd.srch_err = 1'b1;
                state_next   = scrt_pkg::ST_CMP;
            end
            scrt_pkg::ST_CMP: begin
                cmd.srch_cmp = 1'b1;
                if (stat.cand_last) begin
                    state_next = scrt_pkg::ST_SZ_MUL;
                end else begin
                    cmd.srch_adv = 1'b1;
                    state_next   = scrt_pkg::ST_CHK;
                end
            end
            scrt_pkg::ST_SZ_MUL: begin
                cmd.sz_mul = 1'b1;
                state_next = scrt_pkg::ST_SZ_DIV;
            end
            scrt_pkg::ST_SZ_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = scrt_pkg::DIV_SIZE;
                state_next    = scrt_pkg::ST_SZ_WAIT;
            end
            scrt_pkg::ST_SZ_WAIT: begin
                if (!stat.div_busy) begin
                    cmd.sz_load = 1'b1;
                    state_next  = scrt_pkg::ST_SZ_STEP;
                end
            end
            scrt_pkg::ST_SZ_STEP: begin
                cmd.sz_step = 1'b1;
                if (stat.sz_stop) begin
                    state_next = scrt_pkg::ST_NMOD_DIV;
                end
            end
            scrt_pkg::ST_NMOD_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = scrt_pkg::DIV_NMOD;
                state_next    = scrt_pkg::ST_NMOD_WAIT;
            end
            scrt_pkg::ST_NMOD_WAIT: begin
                if (!stat.div_busy) begin
                    cmd.ent_init = 1'b1;
                    state_next   = scrt_pkg::ST_W_DIV;
                end
            end
            scrt_pkg::ST_W_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = scrt_pkg::DIV_WEIGHT;
                state_next    = scrt_pkg::ST_W_WAIT;
            end
            scrt_pkg::ST_W_WAIT: begin
                if (!stat.div_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = scrt_pkg::ST_OUT;
                end
            end
            scrt_pkg::ST_OUT: begin
                if (stat.out_fire) begin
                    cmd.ent_adv = 1'b1;
                    state_next  = stat.ent_last ? scrt_pkg::ST_IDLE : scrt_pkg::ST_W_DIV;
                end
            end
            default: begin
                state_next = scrt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/scrt_dp.sv @@
module scrt_dp #(
    parameter int MAX_TERM  = scrt_pkg::MAX_TERM_DEF,
    parameter int SIZE_BITS = scrt_pkg::SIZE_BITS_DEF,
    localparam int TB = $clog2(MAX_TERM + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  scrt_pkg::cmd_t                   cmd,
    output scrt_pkg::stat_t                  stat,
    input  logic [SIZE_BITS-1:0]             s_src_size,
    input  logic [SIZE_BITS-1:0]             s_dst_size,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic [TB-1:0]                    m_entry_index,
    output logic [scrt_pkg::WEIGHT_BITS-1:0] m_weight,
    output logic                             m_take_input,
    output logic                             m_give_output,
    output logic [TB-1:0]                    m_ratio_num,
    output logic [TB-1:0]                    m_ratio_den,
    output logic                             m_is_upscale,
    output logic [SIZE_BITS-1:0]             m_achieved_size,
    output logic [SIZE_BITS-1:0]             m_trim,
    output logic                             m_last_entry
);

    localparam int PW  = SIZE_BITS + TB;
    localparam int AW  = 2 * TB + 1;
    localparam int CW  = PW + 1;
    localparam int DCW = $clog2(PW + 1);
    localparam int WB  = scrt_pkg::WEIGHT_BITS;
    localparam logic [TB-1:0] TERM_MAX = TB'(MAX_TERM);

    // Input sizes and ratio search.
    logic [SIZE_BITS-1:0] s_reg, d_reg;
    logic                 up_reg;
    logic [TB-1:0]        n_reg, m_reg, best_n_reg, best_m_reg, best_den_reg;
    logic                 have_reg;
    logic [PW-1:0]        prod_a_reg, prod_b_reg, err_reg, best_err_reg;
    logic [PW+TB-1:0]     lhs, rhs;
    logic                 better;

    // Serial divider.
    logic [PW-1:0]  div_num_reg, div_q_reg, div_dividend;
    logic [TB-1:0]  div_den_reg, div_rem_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic           div_busy_reg;
    logic [TB:0]    rem_sh, rem_sub;
    logic           rem_ge;

    // Output size search.
    logic [SIZE_BITS-1:0] delta_reg, ach_reg, trim_reg;
    logic [PW-1:0]        p0_reg, q_reg;
    logic [TB-1:0]        r_reg;
    logic [CW-1:0]        cal;
    logic [TB+1:0]        r1, r2, r3;
    logic [PW-1:0]        q_step;

    // Entry generation.
    logic [TB-1:0]  i_reg, rmod_reg, amod_reg, nmod_reg;
    logic [AW-1:0]  in_reg, tm_reg, a_reg, im1_reg, xn_reg;
    logic [TB-1:0]  count, rmod_nx, amod_nx;
    logic [TB:0]    rmod_sum, amod_sum;
    logic [TB-1:0]  wfac;
    logic           take, give, tadv, c1, c2;
    logic [WB-1:0]  wsel;
    logic [TB-1:0]  out_idx_reg;
    logic [WB-1:0]  out_w_reg;
    logic           out_take_reg, out_give_reg, out_last_reg, out_valid_reg;

    // Search datapath: a candidate costs one multiply stage, one subtract and one compare.
    assign lhs    = (PW+TB)'(err_reg) * (PW+TB)'(best_den_reg);
    assign rhs    = (PW+TB)'(best_err_reg) * (PW+TB)'(m_reg);
    assign better = !have_reg || (lhs < rhs);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            s_reg        <= (s_src_size == '0) ? SIZE_BITS'(1) : s_src_size;
            d_reg        <= (s_dst_size == '0) ? SIZE_BITS'(1) : s_dst_size;
            up_reg       <= ((s_dst_size == '0) ? SIZE_BITS'(1) : s_dst_size)
                            >= ((s_src_size == '0) ? SIZE_BITS'(1) : s_src_size);
            n_reg        <= TB'(1);
            m_reg        <= TB'(1);
            have_reg     <= 1'b0;
            best_den_reg <= TB'(1);
            best_n_reg   <= TB'(1);
            best_m_reg   <= TB'(1);
        end
        if (cmd.srch_mul) begin
            prod_a_reg <= PW'(s_reg) * PW'(m_reg);
            prod_b_reg <= PW'(n_reg) * PW'(d_reg);
        end
        if (cmd.srch_err) begin
            err_reg <= (prod_a_reg > prod_b_reg) ? prod_a_reg - prod_b_reg
                                                 : prod_b_reg - prod_a_reg;
        end
        if (cmd.srch_cmp && better) begin
            have_reg     <= 1'b1;
            best_err_reg <= err_reg;
            best_den_reg <= m_reg;
            best_n_reg   <= n_reg;
            best_m_reg   <= m_reg;
        end
        if (cmd.srch_adv) begin
            if (m_reg == TERM_MAX) begin
                m_reg <= TB'(1);
                n_reg <= n_reg + TB'(1);
            end else begin
                m_reg <= m_reg + TB'(1);
            end
        end
    end

    // Restoring divider, one quotient bit per cycle.
    always_comb begin
        case (cmd.div_sel)
            scrt_pkg::DIV_SIZE:   div_dividend = p0_reg;
            scrt_pkg::DIV_NMOD:   div_dividend = PW'(best_n_reg);
            scrt_pkg::DIV_WEIGHT: div_dividend = PW'({wfac, 7'd0});
            default:              div_dividend = '0;
        endcase
    end

    assign rem_sh  = {div_rem_reg, div_num_reg[PW-1]};
    assign rem_ge  = rem_sh >= {1'b0, div_den_reg};
    assign rem_sub = rem_sh - {1'b0, div_den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
        end else if (cmd.div_start) begin
            div_busy_reg <= 1'b1;
        end else if (div_busy_reg && div_cnt_reg == DCW'(1)) begin
            div_busy_reg <= 1'b0;
        end
        if (cmd.div_start) begin
            div_num_reg <= div_dividend;
            div_den_reg <= (cmd.div_sel == scrt_pkg::DIV_SIZE) ? best_n_reg : best_m_reg;
            div_rem_reg <= '0;
            div_q_reg   <= '0;
            div_cnt_reg <= DCW'(PW);
        end else if (div_busy_reg) begin
            div_rem_reg <= rem_ge ? rem_sub[TB-1:0] : rem_sh[TB-1:0];
            div_num_reg <= {div_num_reg[PW-2:0], 1'b0};
            div_q_reg   <= {div_q_reg[PW-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    // Output size search: k drops by one per step, so the quotient by n is kept
    // up to date with at most two corrections.
    always_comb begin
        if (up_reg) begin
            cal = CW'(q_reg) + ((r_reg == '0) ? CW'(1) : CW'(2));
        end else begin
            cal = CW'(q_reg) + ((r_reg == '0) ? CW'(0) : CW'(1));
        end
        r1     = {2'b00, r_reg} - {2'b00, best_m_reg};
        r2     = r1 + {2'b00, best_n_reg};
        r3     = r2 + {2'b00, best_n_reg};
        q_step = q_reg;
        if (r1[TB+1]) begin
            q_step = q_reg - PW'(1);
            if (r2[TB+1]) begin
                q_step = q_reg - PW'(2);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sz_mul) begin
            p0_reg <= PW'(s_reg - SIZE_BITS'(1)) * PW'(best_m_reg);
        end
        if (cmd.sz_load) begin
            q_reg     <= div_q_reg;
            r_reg     <= div_rem_reg;
            delta_reg <= SIZE_BITS'(1);
        end
        if (cmd.sz_step) begin
            if (stat.sz_stop) begin
                ach_reg  <= cal[SIZE_BITS-1:0];
                trim_reg <= delta_reg - SIZE_BITS'(1);
            end else begin
                delta_reg <= delta_reg + SIZE_BITS'(1);
                q_reg     <= q_step;
                r_reg     <= !r1[TB+1] ? r1[TB-1:0] : (!r2[TB+1] ? r2[TB-1:0] : r3[TB-1:0]);
            end
        end
    end

    // Coefficient entries.
    always_comb begin
        count    = up_reg ? best_m_reg : best_n_reg;
        rmod_sum = {1'b0, rmod_reg} + {1'b0, best_n_reg};
        rmod_nx  = (rmod_sum >= {1'b0, best_m_reg}) ? TB'(rmod_sum - {1'b0, best_m_reg})
                                                    : rmod_sum[TB-1:0];
        amod_sum = {1'b0, amod_reg} + {1'b0, nmod_reg};
        amod_nx  = (amod_sum >= {1'b0, best_m_reg}) ? TB'(amod_sum - {1'b0, best_m_reg})
                                                    : amod_sum[TB-1:0];
        c1       = (a_reg + AW'(1)) >= im1_reg;
        c2       = (a_reg + AW'(1)) == (im1_reg - AW'(best_m_reg));
        tadv     = 1'b0;
        take     = 1'b1;
        give     = 1'b1;
        wsel     = div_q_reg[WB-1:0];
        if (up_reg) begin
            wfac = best_m_reg - rmod_reg;
            take = tm_reg <= in_reg;
        end else begin
            wfac = best_m_reg - TB'(1) - amod_reg;
            if (best_m_reg == TB'(1)) begin
                wsel = (i_reg == '0) ? scrt_pkg::HALF_WEIGHT : '0;
                give = i_reg == '0;
            end else begin
                tadv = !c1;
                if (c1) begin
                    wsel = '0;
                end else if (c2) begin
                    wsel = scrt_pkg::FULL_WEIGHT;
                end
                give = !((xn_reg + AW'(1)) >= im1_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ent_init) begin
            nmod_reg <= div_rem_reg;
            i_reg    <= '0;
            in_reg   <= '0;
            rmod_reg <= '0;
            tm_reg   <= '0;
            a_reg    <= '0;
            amod_reg <= '0;
            im1_reg  <= AW'(best_m_reg);
            xn_reg   <= '0;
        end
        if (cmd.ent_adv) begin
            i_reg    <= i_reg + TB'(1);
            in_reg   <= in_reg + AW'(best_n_reg);
            rmod_reg <= rmod_nx;
            im1_reg  <= im1_reg + AW'(best_m_reg);
            if (up_reg && take) begin
                tm_reg <= tm_reg + AW'(best_m_reg);
            end
            if (tadv) begin
                a_reg    <= a_reg + AW'(best_n_reg);
                amod_reg <= amod_nx;
            end
            if (give) begin
                xn_reg <= xn_reg + AW'(best_n_reg);
            end
        end
        if (cmd.emit) begin
            out_idx_reg  <= i_reg;
            out_w_reg    <= wsel;
            out_take_reg <= take;
            out_give_reg <= give;
            out_last_reg <= (i_reg + TB'(1)) == count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        stat.skip      = {1'b0, m_reg} > {n_reg, 1'b0};
        stat.cand_last = (n_reg == TERM_MAX) && (m_reg == TERM_MAX);
        stat.div_busy  = div_busy_reg;
        stat.sz_stop   = (cal <= CW'(d_reg)) || (delta_reg >= s_reg);
        stat.ent_last  = out_last_reg;
        stat.out_fire  = out_valid_reg && m_ready;
    end

    assign m_valid         = out_valid_reg;
    assign m_entry_index   = out_idx_reg;
    assign m_weight        = out_w_reg;
    assign m_take_input    = out_take_reg;
    assign m_give_output   = out_give_reg;
    assign m_ratio_num     = best_n_reg;
    assign m_ratio_den     = best_m_reg;
    assign m_is_upscale    = up_reg;
    assign m_achieved_size = ach_reg;
    assign m_trim          = trim_reg;
    assign m_last_entry    = out_last_reg;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

// One expected or observed coefficient beat.
typedef struct packed {
    logic [4:0]  idx;
    logic [7:0]  weight;
    logic        take;
    logic        give;
    logic [4:0]  num;
    logic [4:0]  den;
    logic        up;
    logic [11:0] ach;
    logic [11:0] trim;
    logic        last;
} coef_beat_t;

// Scoreboard for the resize coefficient table. Each accepted size pair is
// turned into its full list of expected coefficient beats, which are then
// matched in order against the beats the block produces.
class coef_scoreboard;
    coef_beat_t pending_beats[$];
    int         fail_count;

    function automatic int unsigned gcd(int unsigned a, int unsigned b);
        int unsigned r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Computes the ratio, achieved size and coefficient entries for one
    // dimension and queues one expected beat per entry.
    function void note_sizes(logic [11:0] src_in, logic [11:0] dst_in);
        int unsigned s, d, n, m, bn, bm, cnt, delta, k, p, q, cal, w, tk, gv, t, x, a;
        longint unsigned err, best_err, best_den;
        bit have, up;
        coef_beat_t b;
        s = (src_in == 0) ? 1 : 32'(src_in);
        d = (dst_in == 0) ? 1 : 32'(dst_in);
        up = d >= s;
        have = 0;
        bn = 1;
        bm = 1;
        best_err = 0;
        best_den = 1;
        for (n = 1; n <= 20; n++) begin
            for (m = 1; m <= 20; m++) begin
                if (2 * n < m || gcd(n, m) != 1) continue;
                err = (s * m > n * d) ? s * m - n * d : n * d - s * m;
                if (!have || err * best_den < best_err * m) begin
                    have = 1;
                    best_err = err;
                    best_den = m;
                    bn = n;
                    bm = m;
                end
            end
        end
        n = bn;
        m = bm;
        // Size search: drop source pixels until the output fits the target.
        for (delta = 1; ; delta++) begin
            k = s - delta;
            p = k * m;
            q = p / n;
            cal = q + ((p % n == 0) ? (up ? 1 : 0) : (up ? 2 : 1));
            if (cal <= d || delta >= s) break;
        end
        cnt = up ? m : n;
        t = 0;
        x = 0;
        for (int unsigned i = 0; i < cnt; i++) begin
            if (up) begin
                w = (128 * (m - ((i * n) % m))) / m;
                gv = 1;
                tk = (t * m <= i * n);
                if (tk) t++;
            end else begin
                tk = 1;
                if (m == 1) begin
                    w = (i == 0) ? 64 : 0;
                    gv = (i == 0);
                end else begin
                    a = t * n;
                    if ((a + 1) / m >= i + 1) w = 0;
                    else if (a + 1 == i * m) begin
                        w = 128;
                        t++;
                    end else begin
                        w = (128 * (m - 1 - (a % m))) / m;
                        t++;
                    end
                    if ((x * n + 1) / m >= i + 1) gv = 0;
                    else begin
                        gv = 1;
                        x++;
                    end
                end
            end
            b.idx = 5'(i);
            b.weight = 8'(w);
            b.take = 1'(tk);
            b.give = 1'(gv);
            b.num = 5'(n);
            b.den = 5'(m);
            b.up = up;
            b.ach = 12'(cal);
            b.trim = 12'(delta - 1);
            b.last = (i + 1 == cnt);
            pending_beats.push_back(b);
        end
    endfunction

    function void check_beat(coef_beat_t got);
        coef_beat_t e;
        if (pending_beats.size() == 0) begin
            $display("%0t: unexpected beat, idx %0d", $time, got.idx);
            fail_count++;
            return;
        end
        e = pending_beats.pop_front();
        if (got !== e) begin
            $display("%0t: mismatch expected idx %0d w %0d tk %0d gv %0d n %0d m %0d",
                $time, e.idx, e.weight, e.take, e.give, e.num, e.den);
            $display("    up %0d ach %0d trim %0d last %0d", e.up, e.ach, e.trim, e.last);
            $display("%0t: mismatch actual   idx %0d w %0d tk %0d gv %0d n %0d m %0d",
                $time, got.idx, got.weight, got.take, got.give, got.num, got.den);
            $display("    up %0d ach %0d trim %0d last %0d", got.up, got.ach, got.trim, got.last);
            fail_count++;
        end
    endfunction
endclass

module testbench;
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [11:0] s_src_size;
    logic [11:0] s_dst_size;
    logic        m_valid;
    logic        m_ready;
    logic [4:0]  m_entry_index;
    logic [7:0]  m_weight;
    logic        m_take_input;
    logic        m_give_output;
    logic [4:0]  m_ratio_num;
    logic [4:0]  m_ratio_den;
    logic        m_is_upscale;
    logic [11:0] m_achieved_size;
    logic [11:0] m_trim;
    logic        m_last_entry;

    coef_scoreboard sb = new();

    // Idle percentages for each side; the stimulus process changes them per phase.
    int  send_idle_pct;
    int  recv_stall_pct;
    longint cycle_count;

    scaler_ratio_and_coef_table dut (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // Run limit. Roughly 100 items are sent, each with up to 20 beats under stall;
    // this bound leaves wide margin.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 4_000_000) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // The receiver stalls at random at its current rate. Each beat seen with
    // valid and ready both high at the edge is handed to the scoreboard.
    initial begin
        coef_beat_t got;
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.idx = m_entry_index;
                got.weight = m_weight;
                got.take = m_take_input;
                got.give = m_give_output;
                got.num = m_ratio_num;
                got.den = m_ratio_den;
                got.up = m_is_upscale;
                got.ach = m_achieved_size;
                got.trim = m_trim;
                got.last = m_last_entry;
                sb.check_beat(got);
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Presents one size pair after a random gap, holds it until accepted,
    // and records it with the scoreboard at the accepting edge. Valid stays
    // high afterwards so the next pair can follow directly.
    task automatic send_sizes(logic [11:0] src, logic [11:0] dst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_src_size <= src;
        s_dst_size <= dst;
        do @(posedge aclk); while (!s_ready);
        sb.note_sizes(src, dst);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending_beats.size() != 0) @(posedge aclk);
    endtask

    // Random pair: mostly a legal target within half to twice the source,
    // with small sizes favored so the size search stays short.
    task automatic send_random();
        logic [11:0] s, d;
        int unsigned hi;
        s = ($urandom_range(3) == 0) ? 12'($urandom_range(4095, 1)) : 12'($urandom_range(300, 1));
        hi = (2 * s > 4095) ? 4095 : 2 * 32'(s);
        d = 12'($urandom_range(hi, (32'(s) + 1) / 2));
        case ($urandom_range(9))
            0: d = 12'($urandom_range(4095, 0));
            1: s = 12'($urandom_range(4095, 0));
            default: ;
        endcase
        if ($urandom_range(9) == 0) d = s;
        send_sizes(s, d);
    endtask

    initial begin
        s_valid = 0;
        s_src_size = 0;
        s_dst_size = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part: extremes, zero sizes (treated as one), equal sizes,
        // exact half and double, a target far beyond twice the source, and
        // targets below half the source.
        send_sizes(12'd1, 12'd1);
        send_sizes(12'd0, 12'd0);
        send_sizes(12'd0, 12'd5);
        send_sizes(12'd7, 12'd0);
        send_sizes(12'd4095, 12'd4095);
        send_sizes(12'd4095, 12'd1);
        send_sizes(12'd1, 12'd4095);
        send_sizes(12'd2048, 12'd4095);
        send_sizes(12'd100, 12'd200);
        send_sizes(12'd200, 12'd100);
        send_sizes(12'd320, 12'd240);
        send_sizes(12'd240, 12'd320);
        send_sizes(12'd19, 12'd20);
        send_sizes(12'd20, 12'd19);
        send_sizes(12'd3, 12'd7);
        send_sizes(12'd1365, 12'd2730);
        send_sizes(12'd2730, 12'd1365);
        send_sizes(12'd1234, 12'd2345);
        send_sizes(12'd2863, 12'd2864);

        // The sender holds off here until every expected beat has arrived.
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            repeat (20) send_random();
        end

        drain();
        repeat (200) @(posedge aclk);
        if (sb.fail_count == 0 && sb.pending_beats.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
